>>> src/bps_pkg.sv
// shared constants, stage map and arithmetic helpers for the ball point sampler
package bps_pkg;

    localparam int RAND_BITS = 16;
    localparam int MAG_W     = 24;
    localparam int SCL_W     = 32;
    localparam int PT_W      = 17;

    // pipeline stage map
    localparam int ST_MAP    = 0;
    localparam int ST_SQ     = 1;
    localparam int SQRT_STG  = 12;
    localparam int NORM_STG  = 2 + SQRT_STG;
    localparam int ST_CBRT0  = 1;
    localparam int CBRT_STG  = 16;
    localparam int CBRT_ALL  = CBRT_STG + 1;
    localparam int ST_SCL    = ST_CBRT0 + CBRT_STG;
    localparam int ST_DIV0   = ST_SQ + NORM_STG;
    localparam int DIV_STG   = 16;
    localparam int ST_MUL    = ST_DIV0 + DIV_STG;
    localparam int ST_OUT    = ST_MUL + 1;
    localparam int NSTG      = ST_OUT + 1;

    localparam logic [RAND_BITS-1:0] WORD_FULL  = '1;
    localparam logic [MAG_W-1:0]     MAG_FLOOR  = 24'd839;
    localparam logic [15:0]          RADIUS_RST = 16'd18432;
    localparam logic [18:0]          OUT_LIMIT  = 19'd65535;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
    } t_lane;

    typedef struct packed {
        logic [25:0] rem;
        logic [23:0] res;
    } t_sqst;

    // floor(n / 131070) for the word mapping, n = value * 2^16 + 65535
    function automatic logic [15:0] div_map(input logic [32:0] n);
        logic [15:0] q0;
        logic [17:0] r;
        q0 = n[32:17];
        r  = {1'b0, n[16:0]} + {1'b0, q0, 1'b0};
        return (r >= 18'd131070) ? q0 + 16'd1 : q0;
    endfunction

    // one root digit of the square root
    function automatic t_sqst sqrt_step(input t_sqst st, input logic [1:0] dig);
        logic [27:0] r2;
        logic [27:0] trial;
        t_sqst       o;
        r2    = {st.rem, dig};
        trial = {2'b00, st.res, 2'b01};
        if (r2 >= trial) begin
            r2    = r2 - trial;
            o.res = {st.res[22:0], 1'b1};
        end else begin
            o.res = {st.res[22:0], 1'b0};
        end
        o.rem = r2[25:0];
        return o;
    endfunction

    // digit d (from the top) of s * 2^16
    function automatic logic [1:0] sqrt_digit(input logic [31:0] s, input int d);
        logic [31:0] t;
        t = '0;
        if (d < 16) begin
            t = s >> (30 - 2 * d);
        end
        return t[1:0];
    endfunction

endpackage

>>> src/bps_map.sv
// input stage: maps the raw random words to q1.15 values
module bps_map (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [63:0]             i_data,
    output logic [15:0]             o_u,
    output bps_pkg::t_lane          o_x,
    output bps_pkg::t_lane          o_y,
    output bps_pkg::t_lane          o_z
);
    import bps_pkg::*;

    logic [15:0] r_u;
    t_lane       r_x, r_y, r_z;
    logic [15:0] n_u;
    t_lane       n_x, n_y, n_z;

    function automatic t_lane map_signed(input logic [15:0] w);
        logic [16:0] twice;
        logic [16:0] m;
        t_lane       o;
        twice = {w, 1'b0};
        o.neg = twice < {1'b0, WORD_FULL};
        m     = o.neg ? ({1'b0, WORD_FULL} - twice) : (twice - {1'b0, WORD_FULL});
        o.mag = div_map({1'b0, m[15:0], WORD_FULL});
        return o;
    endfunction

    always_comb begin
        n_u = div_map({1'b0, i_data[15:0], WORD_FULL});
        n_x = map_signed(i_data[31:16]);
        n_y = map_signed(i_data[47:32]);
        n_z = map_signed(i_data[63:48]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_u = r_u;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

>>> src/bps_norm.sv
// vector length: squares, sum and a pipelined square root, floored
module bps_norm (
    input  logic                          i_clk,
    input  logic [bps_pkg::NORM_STG-1:0]  i_en,
    input  logic [15:0]                   i_x,
    input  logic [15:0]                   i_y,
    input  logic [15:0]                   i_z,
    output logic [bps_pkg::MAG_W-1:0]     o_mag
);
    import bps_pkg::*;

    logic [30:0] r_sq [3];
    logic [31:0] r_s;
    t_sqst       r_st [SQRT_STG];
    logic [31:0] r_sv [SQRT_STG];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sq[0] <= 31'({16'b0, i_x} * {16'b0, i_x});
            r_sq[1] <= 31'({16'b0, i_y} * {16'b0, i_y});
            r_sq[2] <= 31'({16'b0, i_z} * {16'b0, i_z});
        end
        if (i_en[1]) begin
            r_s <= 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
        end
    end

    for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
        t_sqst       w_in;
        t_sqst       w_mid;
        t_sqst       n_st;
        logic [31:0] w_s;
        if (k == 0) begin : g_first
            assign w_in = '0;
            assign w_s  = r_s;
        end else begin : g_next
            assign w_in = r_st[k-1];
            assign w_s  = r_sv[k-1];
        end
        always_comb begin
            w_mid = sqrt_step(w_in, sqrt_digit(w_s, 2 * k));
            n_st  = sqrt_step(w_mid, sqrt_digit(w_s, 2 * k + 1));
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k+2]) begin
                r_st[k] <= n_st;
                r_sv[k] <= w_s;
            end
        end
    end

    assign o_mag = (r_st[SQRT_STG-1].res < MAG_FLOOR) ? MAG_FLOOR : r_st[SQRT_STG-1].res;
endmodule

>>> src/bps_cbrt.sv
// radial scale: pipelined cube root of u, then times the radius
module bps_cbrt (
    input  logic                          i_clk,
    input  logic [bps_pkg::CBRT_ALL-1:0]  i_en,
    input  logic [15:0]                   i_u,
    input  logic [15:0]                   i_radius,
    output logic [bps_pkg::SCL_W-1:0]     o_scale
);
    import bps_pkg::*;

    logic [15:0]      r_r  [CBRT_STG];
    logic [31:0]      r_r2 [CBRT_STG];
    logic [49:0]      r_r3 [CBRT_STG];
    logic [15:0]      r_uu [CBRT_STG];
    logic [SCL_W-1:0] r_scale;

    for (genvar k = 0; k < CBRT_STG; k++) begin : g_cbrt
        localparam int B = CBRT_STG - 1 - k;
        logic [15:0] w_r;
        logic [31:0] w_r2;
        logic [49:0] w_r3;
        logic [15:0] w_u;
        logic [15:0] c1;
        logic [31:0] c2;
        logic [49:0] c3;
        logic [49:0] t2;
        logic [49:0] t1;
        logic [49:0] v;
        if (k == 0) begin : g_first
            assign w_r  = '0;
            assign w_r2 = '0;
            assign w_r3 = '0;
            assign w_u  = i_u;
        end else begin : g_next
            assign w_r  = r_r[k-1];
            assign w_r2 = r_r2[k-1];
            assign w_r3 = r_r3[k-1];
            assign w_u  = r_uu[k-1];
        end
        always_comb begin
            c1 = w_r | (16'd1 << B);
            c2 = w_r2 + (32'(w_r) << (B + 1)) + (32'd1 << (2 * B));
            t2 = 50'(w_r2) << B;
            t1 = 50'(w_r) << (2 * B);
            c3 = w_r3 + t2 + (t2 << 1) + t1 + (t1 << 1) + (50'd1 << (3 * B));
            v  = 50'(w_u) << 30;
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_uu[k] <= w_u;
                if (c3 <= v) begin
                    r_r[k]  <= c1;
                    r_r2[k] <= c2;
                    r_r3[k] <= c3;
                end else begin
                    r_r[k]  <= w_r;
                    r_r2[k] <= w_r2;
                    r_r3[k] <= w_r3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CBRT_STG]) begin
            r_scale <= r_r[CBRT_STG-1] * i_radius;
        end
    end

    assign o_scale = r_scale;
endmodule

>>> src/bps_div.sv
// direction component: pipelined restoring divide, one quotient bit per stage
module bps_div (
    input  logic                         i_clk,
    input  logic [bps_pkg::DIV_STG-1:0]  i_en,
    input  logic [15:0]                  i_ax,
    input  logic [bps_pkg::MAG_W-1:0]    i_mag,
    output logic [15:0]                  o_q
);
    import bps_pkg::*;

    logic [24:0] r_rem [DIV_STG];
    logic [24:0] r_d   [DIV_STG];
    logic [15:0] r_low [DIV_STG];
    logic [15:0] r_q   [DIV_STG];

    for (genvar k = 0; k < DIV_STG; k++) begin : g_div
        logic [24:0] w_rem;
        logic [24:0] w_d;
        logic [15:0] w_low;
        logic [15:0] w_q;
        logic [25:0] t;
        logic        take;
        if (k == 0) begin : g_first
            assign w_rem = {1'b0, i_ax, i_mag[23:16]};
            assign w_d   = {i_mag, 1'b0};
            assign w_low = i_mag[15:0];
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_d   = r_d[k-1];
            assign w_low = r_low[k-1];
            assign w_q   = r_q[k-1];
        end
        always_comb begin
            t    = {w_rem, w_low[15]};
            take = t >= {1'b0, w_d};
            if (take) begin
                t = t - {1'b0, w_d};
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= t[24:0];
                r_d[k]   <= w_d;
                r_low[k] <= {w_low[14:0], 1'b0};
                r_q[k]   <= {w_q[14:0], take};
            end
        end
    end

    assign o_q = r_q[DIV_STG-1];
endmodule

>>> src/bps_scale.sv
// output lane: direction times scale, rounding, sign and clamp
module bps_scale (
    input  logic                       i_clk,
    input  logic [1:0]                 i_en,
    input  logic [15:0]                i_q,
    input  logic [bps_pkg::SCL_W-1:0]  i_scale,
    input  logic                       i_neg,
    output logic [bps_pkg::PT_W-1:0]   o_point
);
    import bps_pkg::*;

    logic [47:0]     r_prod;
    logic            r_neg;
    logic [PT_W-1:0] r_pt;
    logic [48:0]     w_sum;
    logic [18:0]     w_p;
    logic [PT_W-1:0] w_mag;

    always_comb begin
        w_sum = {1'b0, r_prod} + (49'd1 << 29);
        w_p   = w_sum[48:30];
        w_mag = (w_p > OUT_LIMIT) ? PT_W'(OUT_LIMIT) : w_p[PT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= i_q * i_scale;
            r_neg  <= i_neg;
        end
        if (i_en[1]) begin
            r_pt <= r_neg ? -w_mag : w_mag;
        end
    end

    assign o_point = r_pt;
endmodule

>>> src/ball_point_sampler.sv
// top level of the ball point sampler
// throughput: one word per cycle while the output is not stalled; the stage count
// is set by the square root and divide pipelines, two and one result bits per stage
// each stage holds its word under backpressure and fills bubbles upstream
// reset clears all valid bits and sets the radius to 4.5
module ball_point_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,   // ball_radius
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // rand_radial, rand_dir_x, rand_dir_y, rand_dir_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata     // point_x, point_y, point_z, zero fill
);
    import bps_pkg::*;

    logic [15:0]      r_radius;
    logic [NSTG-1:0]  r_v;
    logic [NSTG:0]    w_en;
    logic [15:0]      w_u;
    t_lane            w_lane [3];
    logic [MAG_W-1:0] w_mag;
    logic [SCL_W-1:0] w_scale;
    logic [47:0]      r_ax_d  [ST_SQ:ST_DIV0-1];
    logic [2:0]       r_neg_d [ST_SQ:ST_MUL-1];
    logic [SCL_W-1:0] r_scl_d [ST_SCL+1:ST_MUL-1];
    logic [PT_W-1:0]  w_pt [3];

    always_comb begin
        w_en[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= '0;
            r_radius <= RADIUS_RST;
        end else begin
            if (i_cfg_wr_en) begin
                r_radius <= i_cfg_wr_data;
            end
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    bps_map u_map (
        .i_clk  (i_clk),
        .i_en   (w_en[ST_MAP]),
        .i_data (s_axis_tdata),
        .o_u    (w_u),
        .o_x    (w_lane[0]),
        .o_y    (w_lane[1]),
        .o_z    (w_lane[2])
    );

    bps_norm u_norm (
        .i_clk (i_clk),
        .i_en  (w_en[ST_SQ +: NORM_STG]),
        .i_x   (w_lane[0].mag),
        .i_y   (w_lane[1].mag),
        .i_z   (w_lane[2].mag),
        .o_mag (w_mag)
    );

    bps_cbrt u_cbrt (
        .i_clk    (i_clk),
        .i_en     (w_en[ST_CBRT0 +: CBRT_ALL]),
        .i_u      (w_u),
        .i_radius (r_radius),
        .o_scale  (w_scale)
    );

    // side data delayed to line up with the divide and the final multiply
    for (genvar k = ST_SQ; k < ST_MUL; k++) begin : g_neg
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                if (k == ST_SQ) begin
                    r_neg_d[k] <= {w_lane[2].neg, w_lane[1].neg, w_lane[0].neg};
                end else begin
                    r_neg_d[k] <= r_neg_d[(k == ST_SQ) ? k : k - 1];
                end
            end
        end
    end

    for (genvar k = ST_SQ; k < ST_DIV0; k++) begin : g_ax
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                if (k == ST_SQ) begin
                    r_ax_d[k] <= {w_lane[2].mag, w_lane[1].mag, w_lane[0].mag};
                end else begin
                    r_ax_d[k] <= r_ax_d[(k == ST_SQ) ? k : k - 1];
                end
            end
        end
    end

    for (genvar k = ST_SCL + 1; k < ST_MUL; k++) begin : g_scl
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                if (k == ST_SCL + 1) begin
                    r_scl_d[k] <= w_scale;
                end else begin
                    r_scl_d[k] <= r_scl_d[(k == ST_SCL + 1) ? k : k - 1];
                end
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [15:0] w_q;
        bps_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en[ST_DIV0 +: DIV_STG]),
            .i_ax  (r_ax_d[ST_DIV0-1][16*i +: 16]),
            .i_mag (w_mag),
            .o_q   (w_q)
        );
        bps_scale u_scale (
            .i_clk   (i_clk),
            .i_en    (w_en[ST_MUL +: 2]),
            .i_q     (w_q),
            .i_scale (r_scl_d[ST_MUL-1]),
            .i_neg   (r_neg_d[ST_MUL-1][i]),
            .o_point (w_pt[i])
        );
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_v[NSTG-1];
    assign m_axis_tdata  = {5'b0, w_pt[2], w_pt[1], w_pt[0]};

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[0])
        else $error("accepted word not captured in first stage");

    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_MUL] && !w_en[ST_OUT]) |=> r_v[ST_MUL])
        else $error("stalled multiply stage lost its word");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && (r_radius == RADIUS_RST)))
        else $error("reset did not clear output valid and radius");
endmodule
